// ===== rtl/sparse_set_similarity_assert.svh =====
// Assertion macros for the sparse set similarity block.
`ifndef SPARSE_SET_SIMILARITY_ASSERT_SVH
`define SPARSE_SET_SIMILARITY_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define SSS_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SSS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// ===== rtl/sss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse set similarity package
// Shared constants, types and the state encoding of the block.
// ----------------------------------------------------------------------------
package sss_pkg;
    localparam int MAX_LEN = 1024;
    localparam int ID_BITS = 32;
    localparam int COUNT_BITS = 16;
    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int SUM_W = COUNT_BITS + LEN_W + 1;
    localparam int TOT_W = 32;
    localparam int RATIO_W = 17;

    localparam logic [1:0] METRIC_JACCARD = 2'd0;
    localparam logic [1:0] METRIC_OVERLAP = 2'd1;
    localparam logic [1:0] METRIC_HIST = 2'd2;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_WALK,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic [COUNT_BITS-1:0] cnt;
    } t_elem;

    // One cell of the divider chain.
    typedef struct packed {
        logic [SUM_W:0] rem;
        logic [RATIO_W-1:0] q;
    } t_div;
endpackage

// ===== rtl/sparse_set_similarity.sv =====
`timescale 1ns / 1ps
// Flow: a transfer without pair_done is stored in its list; the next is taken at once.
// A pair_done transfer starts the merge walk, which alternates a read over the store
// read ports (ST_READ) and a merge step (ST_WALK) and ends with a last check; the ratio
// then passes the 16 divider cells and is loaded in ST_OUT when the output is free.
// Reset (synchronous, active low) clears both lengths, the drop flag, the metric
// and the output valid; the stores keep their contents and need no clearing.
// ----------------------------------------------------------------------------
// Sparse set similarity
// Loads two sparse lists, merge-walks them and reports a similarity ratio.
// ----------------------------------------------------------------------------
`include "sparse_set_similarity_assert.svh"
module sparse_set_similarity (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_list_sel,
    input  logic        i_element_valid,
    input  logic [31:0] i_item_id,
    input  logic [15:0] i_count,
    input  logic        i_pair_done,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_shared_total,
    output logic [31:0] o_joint_total,
    output logic [16:0] o_similarity,
    output logic        o_overflowed
);
    localparam int AW = sss_pkg::ADDR_W;
    localparam int LW = sss_pkg::LEN_W;
    localparam int SW = sss_pkg::SUM_W;
    localparam int NDIV = 16;
    localparam int DCW = $clog2(NDIV + 2);

    sss_pkg::t_state r_state, n_state;
    logic [1:0] r_metric;
    logic [LW-1:0] r_alen, n_alen, r_blen, n_blen;
    logic r_drop, n_drop;
    logic [LW-1:0] r_i, n_i, r_j, n_j;
    logic [LW-1:0] r_inter, n_inter;
    logic [SW-1:0] r_hmin, n_hmin, r_hmax, n_hmax;
    logic [SW-1:0] r_num, n_num, r_den, n_den;
    logic [DCW-1:0] r_dcnt, n_dcnt;
    logic r_ovalid, n_ovalid;
    logic [31:0] r_shared, n_shared, r_joint, n_joint;
    logic [16:0] r_sim, n_sim;
    logic r_oflow, n_oflow;

    logic accept, a_we, b_we;
    logic [AW-1:0] a_ra, b_ra;
    sss_pkg::t_elem wdata, a_rd, b_rd;
    sss_pkg::t_div chain [NDIV+1];
    logic a_more, b_more;
    logic [LW:0] den_j;

    assign o_ready = (r_state == sss_pkg::ST_LOAD);
    assign accept = i_valid && o_ready;
    assign wdata.id = i_item_id;
    assign wdata.cnt = i_count;
    assign a_we = accept && i_element_valid && !i_list_sel && (r_alen < LW'(sss_pkg::MAX_LEN));
    assign b_we = accept && i_element_valid && i_list_sel && (r_blen < LW'(sss_pkg::MAX_LEN));
    assign a_more = r_i < r_alen;
    assign b_more = r_j < r_blen;
    assign den_j = {1'b0, r_alen} + {1'b0, r_blen} - {1'b0, r_inter};

    sss_store u_store_a (.i_clk, .i_we(a_we), .i_waddr(r_alen[AW-1:0]), .i_wdata(wdata),
        .i_raddr(a_ra), .o_rdata(a_rd));
    sss_store u_store_b (.i_clk, .i_we(b_we), .i_waddr(r_blen[AW-1:0]), .i_wdata(wdata),
        .i_raddr(b_ra), .o_rdata(b_rd));

    // Division starts from the numerator, which is at most the denominator.
    assign chain[0].rem = {1'b0, r_num};
    assign chain[0].q = '0;
    for (genvar k = 0; k < NDIV; k++) begin : g_div
        sss_div_cell u_cell (.i_clk, .i_den(r_den), .i_prev(chain[k]), .o_next(chain[k+1]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sss_pkg::ST_LOAD;
            r_metric <= sss_pkg::METRIC_JACCARD;
            r_alen <= '0;
            r_blen <= '0;
            r_drop <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_metric <= i_cfg_wdata;
            end
            r_alen <= n_alen;
            r_blen <= n_blen;
            r_drop <= n_drop;
            r_ovalid <= n_ovalid;
        end
        r_i <= n_i;
        r_j <= n_j;
        r_inter <= n_inter;
        r_hmin <= n_hmin;
        r_hmax <= n_hmax;
        r_num <= n_num;
        r_den <= n_den;
        r_dcnt <= n_dcnt;
        r_shared <= n_shared;
        r_joint <= n_joint;
        r_sim <= n_sim;
        r_oflow <= n_oflow;
    end

    always_comb begin
        n_state = r_state;
        n_alen = r_alen;
        n_blen = r_blen;
        n_drop = r_drop;
        n_i = r_i;
        n_j = r_j;
        n_inter = r_inter;
        n_hmin = r_hmin;
        n_hmax = r_hmax;
        n_num = r_num;
        n_den = r_den;
        n_dcnt = r_dcnt;
        n_ovalid = r_ovalid && !i_ready;
        n_shared = r_shared;
        n_joint = r_joint;
        n_sim = r_sim;
        n_oflow = r_oflow;
        a_ra = r_i[AW-1:0];
        b_ra = r_j[AW-1:0];
        case (r_state)
            sss_pkg::ST_LOAD: begin
                if (accept) begin
                    if (a_we) n_alen = r_alen + 1'b1;
                    if (b_we) n_blen = r_blen + 1'b1;
                    if (i_element_valid && !a_we && !b_we) n_drop = 1'b1;
                    if (i_pair_done) begin
                        n_state = sss_pkg::ST_READ;
                        n_i = '0;
                        n_j = '0;
                        n_inter = '0;
                        n_hmin = '0;
                        n_hmax = '0;
                    end
                end
            end
            sss_pkg::ST_READ: begin
                n_state = sss_pkg::ST_WALK;
            end
            sss_pkg::ST_WALK: begin
                if (a_more && b_more) begin
                    if (a_rd.id == b_rd.id) begin
                        n_inter = r_inter + 1'b1;
                        if (a_rd.cnt < b_rd.cnt) begin
                            n_hmin = r_hmin + SW'(a_rd.cnt);
                            n_hmax = r_hmax + SW'(b_rd.cnt);
                        end else begin
                            n_hmin = r_hmin + SW'(b_rd.cnt);
                            n_hmax = r_hmax + SW'(a_rd.cnt);
                        end
                        n_i = r_i + 1'b1;
                        n_j = r_j + 1'b1;
                    end else if (a_rd.id < b_rd.id) begin
                        n_hmax = r_hmax + SW'(a_rd.cnt);
                        n_i = r_i + 1'b1;
                    end else begin
                        n_hmax = r_hmax + SW'(b_rd.cnt);
                        n_j = r_j + 1'b1;
                    end
                    n_state = sss_pkg::ST_READ;
                end else if (a_more) begin
                    n_hmax = r_hmax + SW'(a_rd.cnt);
                    n_i = r_i + 1'b1;
                    n_state = sss_pkg::ST_READ;
                end else if (b_more) begin
                    n_hmax = r_hmax + SW'(b_rd.cnt);
                    n_j = r_j + 1'b1;
                    n_state = sss_pkg::ST_READ;
                end else begin
                    if (r_metric == sss_pkg::METRIC_OVERLAP) begin
                        n_num = SW'(r_inter);
                        n_den = (r_alen < r_blen) ? SW'(r_alen) : SW'(r_blen);
                    end else if (r_metric == sss_pkg::METRIC_HIST) begin
                        n_num = r_hmin;
                        n_den = r_hmax;
                    end else begin
                        n_num = SW'(r_inter);
                        n_den = SW'(den_j);
                    end
                    n_dcnt = '0;
                    n_state = sss_pkg::ST_DIV;
                end
            end
            sss_pkg::ST_DIV: begin
                n_dcnt = r_dcnt + 1'b1;
                if (r_dcnt == DCW'(NDIV)) begin
                    n_state = sss_pkg::ST_OUT;
                end
            end
            sss_pkg::ST_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_shared = 32'(r_num);
                    n_joint = 32'(r_den);
                    if (r_alen == '0 || r_blen == '0 || r_den == '0) begin
                        n_sim = '0;
                    end else if (r_num >= r_den) begin
                        n_sim = 17'h10000;
                    end else begin
                        n_sim = chain[NDIV].q;
                    end
                    n_oflow = r_drop;
                    n_alen = '0;
                    n_blen = '0;
                    n_drop = 1'b0;
                    n_state = sss_pkg::ST_LOAD;
                end
            end
            default: n_state = sss_pkg::ST_LOAD;
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_shared_total = r_shared;
    assign o_joint_total = r_joint;
    assign o_similarity = r_sim;
    assign o_overflowed = r_oflow;

    `SSS_ASSERT_IMPL(a_len_bound, i_clk, i_rst_n, 1'b1,
        (r_alen <= LW'(sss_pkg::MAX_LEN)) && (r_blen <= LW'(sss_pkg::MAX_LEN)))
    `SSS_ASSERT_IMPL(a_sim_bound, i_clk, i_rst_n, o_valid, o_similarity <= 17'h10000)
    `SSS_ASSERT_NEXT(a_clear_after, i_clk, i_rst_n,
        (r_state == sss_pkg::ST_OUT) && (!r_ovalid || i_ready),
        (r_alen == '0) && (r_blen == '0) && o_valid)
endmodule

// ===== rtl/sss_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse set similarity element store
// One list memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module sss_store (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [sss_pkg::ADDR_W-1:0] i_waddr,
    input  sss_pkg::t_elem          i_wdata,
    input  logic [sss_pkg::ADDR_W-1:0] i_raddr,
    output sss_pkg::t_elem          o_rdata
);
    sss_pkg::t_elem mem [sss_pkg::MAX_LEN];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// ===== rtl/sss_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse set similarity divider cell
// One restoring division step, registered, handed to the next cell.
// ----------------------------------------------------------------------------
module sss_div_cell (
    input  logic                   i_clk,
    input  logic [sss_pkg::SUM_W-1:0] i_den,
    input  sss_pkg::t_div          i_prev,
    output sss_pkg::t_div          o_next
);
    logic [sss_pkg::SUM_W+1:0] shifted;
    sss_pkg::t_div n_step;

    always_comb begin
        shifted = {i_prev.rem, 1'b0};
        n_step.q = {i_prev.q[sss_pkg::RATIO_W-2:0], 1'b0};
        n_step.rem = shifted[sss_pkg::SUM_W:0];
        if (shifted >= {2'b00, i_den}) begin
            n_step.rem = sss_pkg::SUM_W'(shifted - {2'b00, i_den}) == '0 ? '0 :
                         (sss_pkg::SUM_W+1)'(shifted - {2'b00, i_den});
            n_step.q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        o_next <= n_step;
    end
endmodule
